@@ hw/rtl/ptiu_pkg.sv @@
// Shared types, codes and helpers for the particle table integrator.
package ptiu_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int CNT_W             = 7;
  localparam int DATA_W            = 32;
  localparam int DT_W              = 31;
  localparam int KIND_W            = 2;
  localparam int ACC_W             = 48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PART  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic signed [DATA_W-1:0] life;
    logic        [DT_W-1:0]   delta_t;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]        result_kind;
    logic                     accepted;
    logic signed [DATA_W-1:0] part_x;
    logic signed [DATA_W-1:0] part_y;
    logic signed [DATA_W-1:0] part_z;
    logic signed [DATA_W-1:0] remaining_life;
    logic [CNT_W-1:0]         live_count;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic signed [DATA_W-1:0] life;
  } particle_t;

  function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > ACC_W'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < ACC_W'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/ptiu_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module ptiu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/particle_table_integrator_unit.sv @@
// Particle table with add requests and Euler time-step ticks, compacting survivors.
//
// Input: a request beat is taken when start is high and busy is low. An add
// (req_type 0) appends one particle if the live count is below the capacity
// limit; its acknowledgement appears on the output in the next cycle, and busy
// stays low, so adds can be issued every cycle.
// A tick (req_type 1) raises busy while every particle in the table is read,
// advanced by velocity * delta_t, aged by delta_t and written back compacted,
// then the survivors are read back and issued one beat per cycle with last on
// the final beat. Each stored particle passes the one read port of the memory
// once in the update, and each survivor passes it once more to be issued. A
// tick that leaves no survivor gives a single empty beat.
// Output: each result appears on out_item with out_valid high for exactly one
// cycle; the receiver cannot stall, so no result is ever held back.
// Config: cfg_we writes the capacity limit; values above MAX_PARTICLES clamp.
// Reset empties the table and sets the limit to its maximum; memory contents
// are not cleared, as only entries below the live count are ever read.
module particle_table_integrator_unit #(
  parameter int MAX_PARTICLES = ptiu_pkg::MAX_PARTICLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  ptiu_pkg::in_item_t               in_item,
  output logic                             out_valid,
  output ptiu_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [ptiu_pkg::CNT_W-1:0]       cfg_wdata
);

  localparam int CNT_W  = ptiu_pkg::CNT_W;
  localparam int DATA_W = ptiu_pkg::DATA_W;
  localparam int ACC_W  = ptiu_pkg::ACC_W;
  localparam int AW     = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int PW     = $bits(ptiu_pkg::particle_t);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARTICLES);

  ptiu_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]          cap_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          idx_r;
  logic [CNT_W-1:0]          wr_idx_r;
  logic [ptiu_pkg::DT_W-1:0] dt_r;
  logic                      rd_vld_r;
  logic                      em_vld_r;
  logic                      em_last_r;

  logic                      s2_vld_r;
  logic                      s2_keep_r;
  logic signed [DATA_W-1:0]  s2_pos_x_r, s2_pos_y_r, s2_pos_z_r;
  logic signed [DATA_W-1:0]  s2_vel_x_r, s2_vel_y_r, s2_vel_z_r;
  logic signed [DATA_W-1:0]  s2_life_r;
  logic signed [ACC_W-1:0]   s2_prod_x_r, s2_prod_y_r, s2_prod_z_r;

  logic                      out_valid_r;
  ptiu_pkg::out_item_t       out_item_r, out_item_nxt;
  logic                      out_load;

  logic [CNT_W-1:0]          lim;
  logic                      in_acc;
  logic                      add_acc;
  logic                      add_ok;
  logic                      tick_acc;
  logic                      issue;
  logic                      upd_done;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  ptiu_pkg::particle_t       ram_wp;
  logic [PW-1:0]             ram_rdata;
  ptiu_pkg::particle_t       rd_p;

  logic signed [63:0]        prod_x, prod_y, prod_z;
  logic signed [DATA_W:0]    life_d;
  logic signed [DATA_W-1:0]  life_s;
  logic signed [ACC_W-1:0]   sum_x, sum_y, sum_z;
  ptiu_pkg::particle_t       upd_p;

  assign busy     = (state_r != ptiu_pkg::ST_IDLE);
  assign lim      = (cap_r > MAX_CNT) ? MAX_CNT : cap_r;
  assign in_acc   = start && !busy;
  assign add_acc  = in_acc && (in_item.req_type == ptiu_pkg::REQ_ADD);
  assign tick_acc = in_acc && (in_item.req_type == ptiu_pkg::REQ_TICK);
  assign add_ok   = (cnt_r < lim);
  assign issue    = ((state_r == ptiu_pkg::ST_UPDATE) || (state_r == ptiu_pkg::ST_EMIT))
                    && (idx_r < cnt_r);
  assign upd_done = (state_r == ptiu_pkg::ST_UPDATE) && !issue && !rd_vld_r && !s2_vld_r;

  assign rd_p = ptiu_pkg::particle_t'(ram_rdata);

  // stage 1: products and ageing on the word just read
  assign prod_x = rd_p.vel_x * $signed({1'b0, dt_r});
  assign prod_y = rd_p.vel_y * $signed({1'b0, dt_r});
  assign prod_z = rd_p.vel_z * $signed({1'b0, dt_r});
  assign life_d = rd_p.life - $signed({2'b00, dt_r});
  assign life_s = ptiu_pkg::sat_q(ACC_W'(life_d));

  // stage 2: position sums, saturated
  assign sum_x = ACC_W'(s2_pos_x_r) + s2_prod_x_r;
  assign sum_y = ACC_W'(s2_pos_y_r) + s2_prod_y_r;
  assign sum_z = ACC_W'(s2_pos_z_r) + s2_prod_z_r;

  always_comb begin
    upd_p.pos_x = ptiu_pkg::sat_q(sum_x);
    upd_p.pos_y = ptiu_pkg::sat_q(sum_y);
    upd_p.pos_z = ptiu_pkg::sat_q(sum_z);
    upd_p.vel_x = s2_vel_x_r;
    upd_p.vel_y = s2_vel_y_r;
    upd_p.vel_z = s2_vel_z_r;
    upd_p.life  = s2_life_r;
  end

  always_comb begin
    if (add_acc) begin
      ram_we       = add_ok;
      ram_waddr    = cnt_r[AW-1:0];
      ram_wp.pos_x = in_item.pos_x;
      ram_wp.pos_y = in_item.pos_y;
      ram_wp.pos_z = in_item.pos_z;
      ram_wp.vel_x = in_item.vel_x;
      ram_wp.vel_y = in_item.vel_y;
      ram_wp.vel_z = in_item.vel_z;
      ram_wp.life  = in_item.life;
    end else begin
      ram_we    = s2_vld_r && s2_keep_r;
      ram_waddr = wr_idx_r[AW-1:0];
      ram_wp    = upd_p;
    end
  end

  ptiu_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_PARTICLES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wp),
    .re    (issue),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    out_load     = 1'b0;
    out_item_nxt = '0;
    unique case (state_r)
      ptiu_pkg::ST_IDLE: begin
        if (add_acc) begin
          out_load                = 1'b1;
          out_item_nxt.result_kind = ptiu_pkg::KIND_ACK;
          out_item_nxt.accepted    = add_ok;
          out_item_nxt.live_count  = add_ok ? cnt_r + 1'b1 : cnt_r;
          out_item_nxt.last        = 1'b1;
        end else if (tick_acc) begin
          state_nxt = ptiu_pkg::ST_UPDATE;
        end
      end
      ptiu_pkg::ST_UPDATE: begin
        if (upd_done) begin
          if (wr_idx_r == '0) begin
            state_nxt                = ptiu_pkg::ST_IDLE;
            out_load                 = 1'b1;
            out_item_nxt.result_kind = ptiu_pkg::KIND_EMPTY;
            out_item_nxt.last        = 1'b1;
          end else begin
            state_nxt = ptiu_pkg::ST_EMIT;
          end
        end
      end
      ptiu_pkg::ST_EMIT: begin
        if (em_vld_r) begin
          out_load                    = 1'b1;
          out_item_nxt.result_kind    = ptiu_pkg::KIND_PART;
          out_item_nxt.part_x         = rd_p.pos_x;
          out_item_nxt.part_y         = rd_p.pos_y;
          out_item_nxt.part_z         = rd_p.pos_z;
          out_item_nxt.remaining_life = rd_p.life;
          out_item_nxt.live_count     = cnt_r;
          out_item_nxt.last           = em_last_r;
          if (em_last_r) begin
            state_nxt = ptiu_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = ptiu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptiu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= MAX_CNT;
      cnt_r       <= '0;
      idx_r       <= '0;
      wr_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      em_vld_r    <= 1'b0;
      em_last_r   <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (add_acc && add_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (upd_done) begin
        cnt_r <= wr_idx_r;
      end
      if (tick_acc || upd_done) begin
        idx_r <= '0;
      end else if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (tick_acc) begin
        wr_idx_r <= '0;
      end else if (s2_vld_r && s2_keep_r) begin
        wr_idx_r <= wr_idx_r + 1'b1;
      end
      rd_vld_r    <= issue && (state_r == ptiu_pkg::ST_UPDATE);
      em_vld_r    <= issue && (state_r == ptiu_pkg::ST_EMIT);
      em_last_r   <= issue && (idx_r == cnt_r - 1'b1);
      s2_vld_r    <= rd_vld_r;
      out_valid_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      dt_r <= in_item.delta_t;
    end
    if (rd_vld_r) begin
      s2_pos_x_r  <= rd_p.pos_x;
      s2_pos_y_r  <= rd_p.pos_y;
      s2_pos_z_r  <= rd_p.pos_z;
      s2_vel_x_r  <= rd_p.vel_x;
      s2_vel_y_r  <= rd_p.vel_y;
      s2_vel_z_r  <= rd_p.vel_z;
      s2_prod_x_r <= prod_x[63:16];
      s2_prod_y_r <= prod_y[63:16];
      s2_prod_z_r <= prod_z[63:16];
      s2_life_r   <= life_s;
      s2_keep_r   <= (life_s > 32'sd0);
    end
    if (out_load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ hw/rtl/ptiu_chk.sv @@
// Port-level checks for the particle table integrator, bound to the top level.
module ptiu_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input ptiu_pkg::in_item_t  in_item,
  input logic                out_valid,
  input ptiu_pkg::out_item_t out_item
);

  a_add_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.req_type == ptiu_pkg::REQ_ADD)) |=>
      (out_valid && (out_item.result_kind == ptiu_pkg::KIND_ACK) && out_item.last))
    else $error("add beat not acknowledged in the next cycle");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.result_kind == ptiu_pkg::KIND_EMPTY)) |->
      (out_item.last && (out_item.live_count == '0)))
    else $error("empty tick beat malformed");

  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.result_kind == ptiu_pkg::KIND_PART) && !out_item.last) |=>
      (out_valid && (out_item.result_kind == ptiu_pkg::KIND_PART)
       && $stable(out_item.live_count)))
    else $error("survivor run broken");

  a_acc_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.result_kind != ptiu_pkg::KIND_ACK)) |-> !out_item.accepted)
    else $error("accepted set on tick beat");

endmodule

bind particle_table_integrator_unit ptiu_chk u_ptiu_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

@@ tb/tb_particle_table_integrator_unit.sv @@
// Self-checking testbench for the particle table integrator: adds, ticks and capacity changes.
`timescale 1ns / 100ps

module tb_particle_table_integrator_unit;

  localparam int TABLE_DEPTH = ptiu_pkg::MAX_PARTICLES_DEF;
  localparam int CNT_W       = ptiu_pkg::CNT_W;
  localparam int DATA_W      = ptiu_pkg::DATA_W;
  localparam int DT_W        = ptiu_pkg::DT_W;
  localparam int STALL_LIMIT = 5000;
  localparam int REPORT_CAP  = 100;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  ptiu_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  ptiu_pkg::out_item_t out_item;
  logic                cfg_we    = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata = '0;

  particle_table_integrator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  ptiu_pkg::in_item_t  request_queue[$];
  ptiu_pkg::out_item_t expected_results[$];
  ptiu_pkg::out_item_t head_result;
  ptiu_pkg::particle_t shadow_parts[TABLE_DEPTH];
  int unsigned shadow_count = 0;
  int unsigned shadow_cap   = TABLE_DEPTH;
  bit          steady_drive = 1'b0;
  int          idle_cycles  = 0;
  int          mismatches   = 0;
  int          requests_taken, adds_stored, adds_refused, ticks_taken;
  int          particle_beats, empty_ticks, peak_live, settings_seen;

  function automatic void queue_request(ptiu_pkg::in_item_t it);
    request_queue.insert(request_queue.size(), it);
  endfunction

  function automatic void expect_result(ptiu_pkg::out_item_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic logic signed [DATA_W-1:0] clip32(longint v);
    if (v > longint'(ptiu_pkg::Q_MAX)) return ptiu_pkg::Q_MAX;
    if (v < longint'(ptiu_pkg::Q_MIN)) return ptiu_pkg::Q_MIN;
    return v[DATA_W-1:0];
  endfunction

  // velocity * step in Q16.16, low bits dropped (floor)
  function automatic longint scaled_step(logic signed [DATA_W-1:0] vel, logic [DT_W-1:0] dt);
    longint prod;
    prod = longint'(vel) * longint'({1'b0, dt});
    return prod >>> 16;
  endfunction

  task automatic forecast_request(ptiu_pkg::in_item_t it);
    ptiu_pkg::out_item_t r;
    ptiu_pkg::particle_t p;
    int unsigned lim;
    int unsigned kept;
    logic signed [DATA_W-1:0] new_life;
    lim = (shadow_cap > TABLE_DEPTH) ? TABLE_DEPTH : shadow_cap;
    if (it.req_type == ptiu_pkg::REQ_ADD) begin
      r = '0;
      r.result_kind = ptiu_pkg::KIND_ACK;
      if (shadow_count < lim) begin
        shadow_parts[shadow_count] = '{it.pos_x, it.pos_y, it.pos_z,
                                       it.vel_x, it.vel_y, it.vel_z, it.life};
        shadow_count++;
        r.accepted = 1'b1;
        adds_stored++;
      end else begin
        adds_refused++;
      end
      r.live_count = CNT_W'(shadow_count);
      r.last = 1'b1;
      expect_result(r);
      if (shadow_count > peak_live) peak_live = shadow_count;
    end else begin
      ticks_taken++;
      kept = 0;
      for (int i = 0; i < shadow_count; i++) begin
        p = shadow_parts[i];
        new_life = clip32(longint'(p.life) - longint'({1'b0, it.delta_t}));
        if (new_life > 0) begin
          p.pos_x = clip32(longint'(p.pos_x) + scaled_step(p.vel_x, it.delta_t));
          p.pos_y = clip32(longint'(p.pos_y) + scaled_step(p.vel_y, it.delta_t));
          p.pos_z = clip32(longint'(p.pos_z) + scaled_step(p.vel_z, it.delta_t));
          p.life  = new_life;
          shadow_parts[kept] = p;
          kept++;
        end
      end
      shadow_count = kept;
      if (kept == 0) begin
        r = '0;
        r.result_kind = ptiu_pkg::KIND_EMPTY;
        r.last = 1'b1;
        expect_result(r);
        empty_ticks++;
      end else begin
        for (int i = 0; i < kept; i++) begin
          r = '0;
          r.result_kind    = ptiu_pkg::KIND_PART;
          r.part_x         = shadow_parts[i].pos_x;
          r.part_y         = shadow_parts[i].pos_y;
          r.part_z         = shadow_parts[i].pos_z;
          r.remaining_life = shadow_parts[i].life;
          r.live_count     = CNT_W'(kept);
          r.last           = (i == kept - 1);
          expect_result(r);
          particle_beats++;
        end
      end
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_life();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'h0 - $urandom_range(0, 32'h0001_0000);
      default: return $urandom_range(1, 32'h0008_0000);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] rand_step();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return DT_W'($urandom);
      2:       return '1;
      default: return DT_W'($urandom_range(1, 32'h0002_0000));
    endcase
  endfunction

  function automatic ptiu_pkg::in_item_t add_item(logic [31:0] px, py, pz, vx, vy, vz, lf);
    ptiu_pkg::in_item_t it;
    it.req_type = ptiu_pkg::REQ_ADD;
    it.pos_x    = px;
    it.pos_y    = py;
    it.pos_z    = pz;
    it.vel_x    = vx;
    it.vel_y    = vy;
    it.vel_z    = vz;
    it.life     = lf;
    it.delta_t  = DT_W'($urandom);
    return it;
  endfunction

  // position, velocity and life fields are don't-care on a tick
  function automatic ptiu_pkg::in_item_t tick_item(logic [DT_W-1:0] dt);
    ptiu_pkg::in_item_t it;
    it = add_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    it.req_type = ptiu_pkg::REQ_TICK;
    it.delta_t  = dt;
    return it;
  endfunction

  function automatic ptiu_pkg::in_item_t rand_add();
    return add_item(rand_coord(), rand_coord(), rand_coord(),
                    rand_vel(), rand_vel(), rand_vel(), rand_life());
  endfunction

  task automatic queue_random_phase(int budget, bit fill_first);
    int queued;
    int burst;
    queued = 0;
    if (fill_first) begin
      repeat (TABLE_DEPTH + 2) begin
        queue_request(add_item(rand_coord(), rand_coord(), rand_coord(),
                               rand_vel(), rand_vel(), rand_vel(),
                               $urandom_range(32'h0004_0000, 32'h0010_0000)));
      end
    end
    while (queued < budget) begin
      burst = $urandom_range(1, 10);
      repeat (burst) queue_request(rand_add());
      queued += burst;
      burst = $urandom_range(1, 3);
      repeat (burst) queue_request(tick_item(rand_step()));
      queued += burst;
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (request_queue.size() != 0 || start || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(int unsigned v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_cap = v;
    settings_seen++;
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        forecast_request(in_item);
        requests_taken++;
      end
      if (!start || !busy) begin
        if (request_queue.size() != 0 && (steady_drive || $urandom_range(0, 99) >= 36)) begin
          start   <= 1'b1;
          in_item <= request_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $error("unexpected result beat, kind %0d", out_item.result_kind);
      end else begin
        head_result = expected_results.pop_front();
        check_field("result_kind", head_result.result_kind, out_item.result_kind);
        check_field("accepted", head_result.accepted, out_item.accepted);
        check_field("part_x", head_result.part_x, out_item.part_x);
        check_field("part_y", head_result.part_y, out_item.part_y);
        check_field("part_z", head_result.part_z, out_item.part_z);
        check_field("remaining_life", head_result.remaining_life, out_item.remaining_life);
        check_field("live_count", head_result.live_count, out_item.live_count);
        check_field("last", head_result.last, out_item.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned cap;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset capacity: empty tick, extremes, nonpositive lives, saturation, floor
    queue_request(tick_item(31'h0001_0000));
    queue_request(add_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h7fff_ffff));
    queue_request(add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7fff_ffff));
    queue_request(add_item(32'h0, 32'h0001_0000, 32'hffff_0000,
                           32'h0001_8000, 32'hfffe_8000, 32'h1, 32'h0));
    queue_request(add_item($urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, 32'hffff_ffff));
    queue_request(add_item($urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, 32'h8000_0000));
    queue_request(tick_item('0));
    queue_request(tick_item(31'h0001_0000));
    queue_request(add_item(32'h0000_1000, 32'hffff_f000, 32'h0,
                           32'hffff_ffff, 32'hffff_8001, 32'h0000_7fff,
                           32'h0003_0000));
    queue_request(tick_item(31'h0000_8000));
    queue_request(tick_item('1));
    wait_quiet();

    set_capacity(0);
    queue_request(rand_add());
    queue_request(tick_item(31'h0000_4000));
    wait_quiet();

    set_capacity(1);
    queue_request(add_item(32'h1, 32'h2, 32'h3, 32'h0001_0000,
                           32'h0, 32'hffff_0000, 32'h0002_0000));
    queue_request(rand_add());
    queue_request(tick_item(31'h0000_8000));
    wait_quiet();

    // lower the limit below the live count
    set_capacity(TABLE_DEPTH);
    repeat (5) queue_request(add_item(rand_coord(), rand_coord(), rand_coord(),
                                      rand_vel(), rand_vel(), rand_vel(),
                                      32'h0100_0000));
    wait_quiet();
    set_capacity(2);
    queue_request(rand_add());
    queue_request(tick_item(31'h0000_2000));
    wait_quiet();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0, 5:    cap = TABLE_DEPTH;
        1:       cap = 1;
        2:       cap = 127;
        3:       cap = 0;
        6:       cap = 100;
        default: cap = $urandom_range(2, TABLE_DEPTH - 1);
      endcase
      set_capacity(cap);
      steady_drive = (p == 5);
      queue_random_phase(38, p == 2);
      wait_quiet();
    end
    steady_drive = 1'b0;
    repeat (20) @(posedge clk);

    $display("Run covered %0d requests: %0d adds stored, %0d refused, %0d ticks",
             requests_taken, adds_stored, adds_refused, ticks_taken);
    $display("%0d survivor beats, %0d empty ticks, %0d capacity writes, peak table %0d",
             particle_beats, empty_ticks, settings_seen, peak_live);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ particle_table_integrator_unit.f @@
hw/rtl/ptiu_pkg.sv
hw/rtl/ptiu_ram.sv
hw/rtl/particle_table_integrator_unit.sv
hw/rtl/ptiu_chk.sv
tb/tb_particle_table_integrator_unit.sv
